// ===== rtl/eci_pkg.sv =====
`timescale 1ns / 1ps
// Shared widths, curve codes, constants and the queue entry type of the easing-curve interpolator.
// Depends on nothing; every other file refers to it by scoped names.
package eci_pkg;

	localparam int FRACTION_BITS = 16;
	localparam int VALUE_BITS    = 32;

	// time fraction, unity and half in Q0.F
	localparam int TW   = FRACTION_BITS + 1;
	localparam int ONE  = 1 << FRACTION_BITS;
	localparam int HALF = ONE >> 1;

	// square operand, scaled bounce time, square, back slope constant
	localparam int AW  = FRACTION_BITS + 2;
	localparam int EW  = FRACTION_BITS + 5;
	localparam int SQW = 2 * AW;
	localparam int KW  = FRACTION_BITS + 2;
	localparam int LPW = KW + AW;

	// signed curve value, back terms and their product
	localparam int CW   = FRACTION_BITS + 3;
	localparam int T2W  = FRACTION_BITS + 2;
	localparam int LINW = FRACTION_BITS + 3;
	localparam int BPW  = T2W + 1 + LINW;

	// difference, full product, rounded product, sum
	localparam int DW = VALUE_BITS + 1;
	localparam int PW = DW + CW;
	localparam int QW = PW - FRACTION_BITS;
	localparam int RW = QW + 1;

	// cycles from the accepting edge to the edge that takes the result
	localparam int LATENCY = 8;

	// back-curve constants rounded to Q.F
	localparam longint BACK_C1 =
		((longint'(170158) << FRACTION_BITS) + 50000) / 100000;
	localparam longint BACK_C2 =
		((longint'(259490950) << FRACTION_BITS) + 50000000) / 100000000;

	// curve codes
	localparam logic [3:0] CMD_LINEAR       = 4'd0;
	localparam logic [3:0] CMD_QUAD_IN      = 4'd1;
	localparam logic [3:0] CMD_QUAD_OUT     = 4'd2;
	localparam logic [3:0] CMD_QUAD_INOUT   = 4'd3;
	localparam logic [3:0] CMD_BOUNCE_OUT   = 4'd4;
	localparam logic [3:0] CMD_BOUNCE_IN    = 4'd5;
	localparam logic [3:0] CMD_BOUNCE_INOUT = 4'd6;
	localparam logic [3:0] CMD_BACK_IN      = 4'd7;
	localparam logic [3:0] CMD_BACK_OUT     = 4'd8;
	localparam logic [3:0] CMD_BACK_INOUT   = 4'd9;

	// bounce segments
	localparam logic [1:0] SEG_FIRST  = 2'd0;
	localparam logic [1:0] SEG_SECOND = 2'd1;
	localparam logic [1:0] SEG_THIRD  = 2'd2;
	localparam logic [1:0] SEG_LAST   = 2'd3;

	// one classified word between front and back
	typedef struct packed {
		logic [3:0]                   cmd;
		logic                         hi;
		logic [1:0]                   seg;
		logic [AW-1:0]                a;
		logic signed [VALUE_BITS-1:0] start;
		logic signed [DW-1:0]         dif;
	} entry_t;

endpackage

// ===== rtl/easing_curve_interpolator_top.sv =====
`timescale 1ns / 1ps
// Top level of the easing-curve interpolator: front end, queue and back-end pipeline.
// Depends on eci_pkg, eci_front, eci_queue and eci_back.
//
// Evaluates one of ten easing curves (linear, quad, bounce, back) at a Q0.16 time
// fraction and returns start + (end - start) * curve, rounded and saturated, with a
// clip flag. A word is taken on any clock where start is high and busy is low, one
// word per clock sustained. Its result appears on done, eased_value and clipped for
// one cycle, after it passes through the two-entry queue and the seven-stage back-end
// pipeline. The receiver cannot stall, so the back end drains every cycle and busy
// stays low in operation.
module easing_curve_interpolator_top (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	output logic                                  busy,
	input  logic [3:0]                            command,
	input  logic signed [eci_pkg::VALUE_BITS-1:0] start_value,
	input  logic signed [eci_pkg::VALUE_BITS-1:0] end_value,
	input  logic [eci_pkg::TW-1:0]                time_fraction,
	output logic                                  done,
	output logic signed [eci_pkg::VALUE_BITS-1:0] eased_value,
	output logic                                  clipped
);
	eci_pkg::entry_t front_word, head_word;
	logic            full, not_empty, push;

	assign busy = full;
	assign push = start && !full;

	eci_front u_front (
		.command       (command),
		.start_value   (start_value),
		.end_value     (end_value),
		.time_fraction (time_fraction),
		.entry         (front_word)
	);

	eci_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_word (front_word),
		.pop       (1'b1),
		.full      (full),
		.not_empty (not_empty),
		.head      (head_word)
	);

	eci_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (not_empty),
		.in_word     (head_word),
		.done        (done),
		.eased_value (eased_value),
		.clipped     (clipped)
	);

endmodule

// ===== rtl/eci_front.sv =====
`timescale 1ns / 1ps
// Front end: clamps the time fraction, picks the squared operand and bounce segment.
// Depends on eci_pkg.
module eci_front (
	input  logic [3:0]                            command,
	input  logic signed [eci_pkg::VALUE_BITS-1:0] start_value,
	input  logic signed [eci_pkg::VALUE_BITS-1:0] end_value,
	input  logic [eci_pkg::TW-1:0]                time_fraction,
	output eci_pkg::entry_t                       entry
);
	localparam logic [eci_pkg::TW-1:0] T_ONE  = eci_pkg::TW'(eci_pkg::ONE);
	localparam logic [eci_pkg::TW-1:0] T_HALF = eci_pkg::TW'(eci_pkg::HALF);
	localparam logic [eci_pkg::TW:0]   T2_ONE = (eci_pkg::TW+1)'(eci_pkg::ONE);
	localparam logic [eci_pkg::TW:0]   T2_TWO = (eci_pkg::TW+1)'(2 * eci_pkg::ONE);
	localparam logic [eci_pkg::EW-1:0] E4  = eci_pkg::EW'(4 * eci_pkg::ONE);
	localparam logic [eci_pkg::EW-1:0] E6  = eci_pkg::EW'(6 * eci_pkg::ONE);
	localparam logic [eci_pkg::EW-1:0] E8  = eci_pkg::EW'(8 * eci_pkg::ONE);
	localparam logic [eci_pkg::EW-1:0] E9  = eci_pkg::EW'(9 * eci_pkg::ONE);
	localparam logic [eci_pkg::EW-1:0] E10 = eci_pkg::EW'(10 * eci_pkg::ONE);
	localparam logic [eci_pkg::EW-1:0] E21 = eci_pkg::EW'(21 * eci_pkg::ONE);

	logic [eci_pkg::TW-1:0] t, s, u;
	logic [eci_pkg::TW:0]   t2x;
	logic                   hi;
	logic [eci_pkg::EW-1:0] e, e22, ba;
	logic [1:0]             seg;

	// clamp time and form its mirror
	always_comb begin
		t   = (time_fraction > T_ONE) ? T_ONE : time_fraction;
		s   = T_ONE - t;
		hi  = (t >= T_HALF);
		t2x = {t, 1'b0};
	end

	// bounce argument, scaled by eleven, segment and distance to segment center
	always_comb begin
		case (command)
			eci_pkg::CMD_BOUNCE_IN: u = s;
			eci_pkg::CMD_BOUNCE_INOUT: u = hi ? eci_pkg::TW'(t2x - T2_ONE)
				: eci_pkg::TW'(T2_ONE - t2x);
			default: u = t;
		endcase
		e   = (eci_pkg::EW'(u) << 3) + (eci_pkg::EW'(u) << 1) + eci_pkg::EW'(u);
		e22 = e << 1;
		if (e < E4) begin
			seg = eci_pkg::SEG_FIRST;
			ba  = e;
		end else if (e < E8) begin
			seg = eci_pkg::SEG_SECOND;
			ba  = (e >= E6) ? e - E6 : E6 - e;
		end else if (e < E10) begin
			seg = eci_pkg::SEG_THIRD;
			ba  = (e >= E9) ? e - E9 : E9 - e;
		end else begin
			seg = eci_pkg::SEG_LAST;
			ba  = (e22 >= E21) ? e22 - E21 : E21 - e22;
		end
	end

	// choose the operand the back end squares
	always_comb begin
		entry.cmd   = command;
		entry.hi    = hi;
		entry.seg   = seg;
		entry.start = start_value;
		entry.dif   = eci_pkg::DW'(end_value) - eci_pkg::DW'(start_value);
		case (command)
			eci_pkg::CMD_QUAD_IN:      entry.a = eci_pkg::AW'(t);
			eci_pkg::CMD_QUAD_OUT:     entry.a = eci_pkg::AW'(s);
			eci_pkg::CMD_QUAD_INOUT:   entry.a = hi ? eci_pkg::AW'(s) : eci_pkg::AW'(t);
			eci_pkg::CMD_BOUNCE_OUT,
			eci_pkg::CMD_BOUNCE_IN,
			eci_pkg::CMD_BOUNCE_INOUT: entry.a = eci_pkg::AW'(ba);
			eci_pkg::CMD_BACK_IN:      entry.a = eci_pkg::AW'(t);
			eci_pkg::CMD_BACK_OUT:     entry.a = eci_pkg::AW'(s);
			eci_pkg::CMD_BACK_INOUT:   entry.a = hi ? eci_pkg::AW'(T2_TWO - t2x)
				: eci_pkg::AW'(t2x);
			default:                   entry.a = eci_pkg::AW'(t);
		endcase
	end

endmodule

// ===== rtl/eci_queue.sv =====
`timescale 1ns / 1ps
// Two-entry queue of classified words between the front and back ends.
// Depends on eci_pkg.
module eci_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  eci_pkg::entry_t push_word,
	input  logic            pop,
	output logic            full,
	output logic            not_empty,
	output eci_pkg::entry_t head
);
	eci_pkg::entry_t mem_q [2];
	logic            wr_ptr_q, rd_ptr_q;
	logic [1:0]      cnt_q;
	logic            do_pop;

	assign full      = (cnt_q == 2'd2);
	assign not_empty = (cnt_q != 2'd0);
	assign head      = mem_q[rd_ptr_q];
	assign do_pop    = pop && not_empty;

	// store pushed words
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_word;
		end
	end

	// advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (do_pop) rd_ptr_q <= ~rd_ptr_q;
			cnt_q <= cnt_q + 2'(push) - 2'(do_pop);
		end
	end

endmodule

// ===== rtl/eci_back.sv =====
`timescale 1ns / 1ps
// Back end: seven-stage pipeline that evaluates the curve and scales the difference.
// Depends on eci_pkg.
module eci_back (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	input  eci_pkg::entry_t                       in_word,
	output logic                                  done,
	output logic signed [eci_pkg::VALUE_BITS-1:0] eased_value,
	output logic                                  clipped
);
	localparam int F = eci_pkg::FRACTION_BITS;
	localparam logic [eci_pkg::KW-1:0] K1 = eci_pkg::KW'(eci_pkg::BACK_C1 + eci_pkg::ONE);
	localparam logic [eci_pkg::KW-1:0] K2 = eci_pkg::KW'(eci_pkg::BACK_C2 + eci_pkg::ONE);
	localparam logic signed [eci_pkg::LINW-1:0] C1 = eci_pkg::LINW'(eci_pkg::BACK_C1);
	localparam logic signed [eci_pkg::LINW-1:0] C2 = eci_pkg::LINW'(eci_pkg::BACK_C2);
	localparam logic signed [eci_pkg::CW-1:0] C_ONE = eci_pkg::CW'(eci_pkg::ONE);
	localparam logic signed [eci_pkg::CW-1:0] C_LSB = eci_pkg::CW'(1);
	localparam logic [eci_pkg::SQW-1:0] RND15 = eci_pkg::SQW'(1) << (F - 2);
	localparam logic [eci_pkg::SQW-1:0] RND16 = eci_pkg::SQW'(1) << (F - 1);
	localparam logic [eci_pkg::SQW-1:0] RND20 = eci_pkg::SQW'(1) << (F + 3);
	localparam logic [eci_pkg::SQW-1:0] RND22 = eci_pkg::SQW'(1) << (F + 5);
	localparam logic [eci_pkg::LPW-1:0] LP_RND = eci_pkg::LPW'(1) << (F - 1);
	localparam logic signed [eci_pkg::BPW-1:0] BP_RND16 = eci_pkg::BPW'(1) << (F - 1);
	localparam logic signed [eci_pkg::BPW-1:0] BP_RND17 = eci_pkg::BPW'(1) << F;
	localparam logic signed [eci_pkg::PW-1:0]  P_RND    = eci_pkg::PW'(1) << (F - 1);
	localparam logic signed [eci_pkg::RW-1:0]  R_MAX =
		eci_pkg::RW'((longint'(1) << (eci_pkg::VALUE_BITS - 1)) - 1);
	localparam logic signed [eci_pkg::RW-1:0]  R_MIN =
		eci_pkg::RW'(-(longint'(1) << (eci_pkg::VALUE_BITS - 1)));

	// stage 1: squares and back slope product
	logic                              v_s1, hi_s1;
	logic [3:0]                        cmd_s1;
	logic [1:0]                        seg_s1;
	logic [eci_pkg::AW-1:0]            a_s1;
	logic [eci_pkg::SQW-1:0]           sq_s1;
	logic [eci_pkg::LPW-1:0]           lp_s1;
	logic signed [eci_pkg::VALUE_BITS-1:0] st_s1, st_s2, st_s3, st_s4, st_s5, st_s6;
	logic signed [eci_pkg::DW-1:0]     dif_s1, dif_s2, dif_s3, dif_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		cmd_s1 <= in_word.cmd;
		hi_s1  <= in_word.hi;
		seg_s1 <= in_word.seg;
		a_s1   <= in_word.a;
		st_s1  <= in_word.start;
		dif_s1 <= in_word.dif;
		sq_s1  <= in_word.a * in_word.a;
		lp_s1  <= ((in_word.cmd == eci_pkg::CMD_BACK_INOUT) ? eci_pkg::LPW'(K2)
			: eci_pkg::LPW'(K1)) * eci_pkg::LPW'(in_word.a);
	end

	// stage 2: round squares, finish quad and bounce curves, form back terms
	logic                            v_s2, hi_s2;
	logic [3:0]                      cmd_s2;
	logic signed [eci_pkg::CW-1:0]   c_s2;
	logic [eci_pkg::T2W-1:0]         t2_s2;
	logic signed [eci_pkg::LINW-1:0] lin_s2;
	logic signed [eci_pkg::CW-1:0]   sqr16, sqr15, bsq, bo, c2;
	logic [eci_pkg::SQW-1:0]         sq_a, sq_b, sq_c, sq_d;

	always_comb begin
		sq_a  = (sq_s1 + RND16) >> F;
		sq_b  = (sq_s1 + RND15) >> (F - 1);
		sq_c  = (sq_s1 + RND20) >> (F + 4);
		sq_d  = (sq_s1 + RND22) >> (F + 6);
		sqr16 = eci_pkg::CW'(sq_a);
		sqr15 = eci_pkg::CW'(sq_b);
		bsq   = (seg_s1 == eci_pkg::SEG_LAST) ? eci_pkg::CW'(sq_d) : eci_pkg::CW'(sq_c);
		// add the segment floor
		case (seg_s1)
			eci_pkg::SEG_SECOND: bo = bsq + eci_pkg::CW'(eci_pkg::ONE * 3 / 4);
			eci_pkg::SEG_THIRD:  bo = bsq + eci_pkg::CW'(eci_pkg::ONE * 15 / 16);
			eci_pkg::SEG_LAST:   bo = bsq + eci_pkg::CW'(eci_pkg::ONE * 63 / 64);
			default:             bo = bsq;
		endcase
		case (cmd_s1)
			eci_pkg::CMD_QUAD_IN:      c2 = sqr16;
			eci_pkg::CMD_QUAD_OUT:     c2 = C_ONE - sqr16;
			eci_pkg::CMD_QUAD_INOUT:   c2 = hi_s1 ? C_ONE - sqr15 : sqr15;
			eci_pkg::CMD_BOUNCE_OUT:   c2 = bo;
			eci_pkg::CMD_BOUNCE_IN:    c2 = C_ONE - bo;
			eci_pkg::CMD_BOUNCE_INOUT: c2 = hi_s1 ? (C_ONE + bo + C_LSB) >>> 1
				: (C_ONE - bo + C_LSB) >>> 1;
			default:                   c2 = eci_pkg::CW'(a_s1);
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		cmd_s2 <= cmd_s1;
		hi_s2  <= hi_s1;
		st_s2  <= st_s1;
		dif_s2 <= dif_s1;
		c_s2   <= c2;
		t2_s2  <= eci_pkg::T2W'(sq_a);
		lin_s2 <= eci_pkg::LINW'((lp_s1 + LP_RND) >> F)
			- ((cmd_s1 == eci_pkg::CMD_BACK_INOUT) ? C2 : C1);
	end

	// stage 3: back product
	logic                           v_s3, hi_s3;
	logic [3:0]                     cmd_s3;
	logic signed [eci_pkg::CW-1:0]  c_s3;
	logic signed [eci_pkg::BPW-1:0] bp_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		cmd_s3 <= cmd_s2;
		hi_s3  <= hi_s2;
		st_s3  <= st_s2;
		dif_s3 <= dif_s2;
		c_s3   <= c_s2;
		bp_s3  <= eci_pkg::BPW'($signed({1'b0, t2_s2})) * eci_pkg::BPW'(lin_s2);
	end

	// stage 4: finish back curves
	logic                           v_s4;
	logic signed [eci_pkg::CW-1:0]  c_s4, c4, rb16, rb17;
	logic signed [eci_pkg::BPW-1:0] bq16, bq17;

	always_comb begin
		bq16 = (bp_s3 + BP_RND16) >>> F;
		bq17 = (bp_s3 + BP_RND17) >>> (F + 1);
		rb16 = eci_pkg::CW'(bq16);
		rb17 = eci_pkg::CW'(bq17);
		case (cmd_s3)
			eci_pkg::CMD_BACK_IN:    c4 = rb16;
			eci_pkg::CMD_BACK_OUT:   c4 = C_ONE - rb16;
			eci_pkg::CMD_BACK_INOUT: c4 = hi_s3 ? C_ONE - rb17 : rb17;
			default:                 c4 = c_s3;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		st_s4  <= st_s3;
		dif_s4 <= dif_s3;
		c_s4   <= c4;
	end

	// stage 5: scale the difference
	logic                          v_s5;
	logic signed [eci_pkg::PW-1:0] p_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		st_s5 <= st_s4;
		p_s5  <= eci_pkg::PW'(dif_s4) * eci_pkg::PW'(c_s4);
	end

	// stage 6: round the product, halves up
	logic                          v_s6;
	logic signed [eci_pkg::QW-1:0] q_s6;
	logic signed [eci_pkg::PW-1:0] pr;

	assign pr = (p_s5 + P_RND) >>> F;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else begin
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		st_s6 <= st_s5;
		q_s6  <= eci_pkg::QW'(pr);
	end

	// stage 7: add start, saturate, drive result
	logic                          done_q, clip_q;
	logic signed [eci_pkg::VALUE_BITS-1:0] val_q;
	logic signed [eci_pkg::RW-1:0] r;

	assign r = eci_pkg::RW'(st_s6) + eci_pkg::RW'(q_s6);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (r > R_MAX) begin
			val_q  <= eci_pkg::VALUE_BITS'(R_MAX);
			clip_q <= 1'b1;
		end else if (r < R_MIN) begin
			val_q  <= eci_pkg::VALUE_BITS'(R_MIN);
			clip_q <= 1'b1;
		end else begin
			val_q  <= eci_pkg::VALUE_BITS'(r);
			clip_q <= 1'b0;
		end
	end

	assign done        = done_q;
	assign eased_value = val_q;
	assign clipped     = clip_q;

endmodule

// ===== rtl/eci_checker.sv =====
`timescale 1ns / 1ps
// Port-level checker for the easing-curve interpolator, bound to the top level.
// Depends on eci_pkg and easing_curve_interpolator_top.
module eci_checker (
	input logic                                  clk,
	input logic                                  arst_n,
	input logic                                  start,
	input logic                                  busy,
	input logic                                  done,
	input logic signed [eci_pkg::VALUE_BITS-1:0] eased_value,
	input logic                                  clipped
);
	localparam logic signed [eci_pkg::VALUE_BITS-1:0] V_MAX =
		eci_pkg::VALUE_BITS'((longint'(1) << (eci_pkg::VALUE_BITS - 1)) - 1);
	localparam logic signed [eci_pkg::VALUE_BITS-1:0] V_MIN =
		eci_pkg::VALUE_BITS'(-(longint'(1) << (eci_pkg::VALUE_BITS - 1)));

	// every result traces back to an accepted word
	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, eci_pkg::LATENCY))
		else $error("result without accepted word");

	// every accepted word yields a result
	a_no_loss: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##(eci_pkg::LATENCY) done)
		else $error("accepted word lost");

	// a clipped result sits at a range limit
	a_clip_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(done && clipped) |-> (eased_value == V_MAX || eased_value == V_MIN))
		else $error("clipped result not at a limit");

	// back end drains every cycle, so the queue never fills
	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!busy)
		else $error("queue filled");

endmodule

bind easing_curve_interpolator_top eci_checker u_eci_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.start       (start),
	.busy        (busy),
	.done        (done),
	.eased_value (eased_value),
	.clipped     (clipped)
);
